// ===== rtl/context_map_rle_mtf_decoder_assert.svh =====
// Assertion macros for the context map decoder.
// Included by the top level; no other dependencies.
`ifndef CONTEXT_MAP_RLE_MTF_DECODER_ASSERT_SVH
`define CONTEXT_MAP_RLE_MTF_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define CMRM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CMRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CMRM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define CMRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/cmrm_pkg.sv =====
// Shared types and constants of the context map decoder.
// No dependencies.
package cmrm_pkg;

	localparam int MAP_SIZE_W = 15;
	localparam int LIMIT_W    = 5;
	localparam int SYMBOL_W   = 9;
	localparam int EXTRA_W    = 16;
	localparam int VALUE_W    = 8;
	localparam int COUNT_W    = 17;
	localparam int MTF_ENTRIES = 256;
	localparam int CFG_INDEX_W = 2;
	localparam logic [LIMIT_W-1:0] MAX_RUN_PREFIX = 5'd16;

	localparam logic [CFG_INDEX_W-1:0] CFG_MAP_SIZE         = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RUN_PREFIX_LIMIT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MTF_ENABLE       = 2'd2;

	typedef struct packed {
		logic                first_symbol;
		logic [SYMBOL_W-1:0] symbol;
		logic [EXTRA_W-1:0]  extra_bits;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
		logic               overflow_error;
		logic               map_complete;
	} out_item_t;

	typedef struct packed {
		logic                  first;
		logic [VALUE_W-1:0]    index;
		logic [COUNT_W-1:0]    length;
	} cls_item_t;

	typedef struct packed {
		logic [MAP_SIZE_W-1:0] map_size;
		logic [LIMIT_W-1:0]    run_prefix_limit;
		logic                  mtf_enable;
	} cfg_t;

endpackage

// ===== rtl/cmrm_fifo.sv =====
// Small synchronous queue used between the decoder stages.
// No dependencies.
module cmrm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [ADDR_W:0]  wr_ptr_q;
	logic [ADDR_W:0]  rd_ptr_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (wr_ptr_q == rd_ptr_q);
	assign full    = (wr_ptr_q[ADDR_W] != rd_ptr_q[ADDR_W]) &&
		(wr_ptr_q[ADDR_W-1:0] == rd_ptr_q[ADDR_W-1:0]);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q[ADDR_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q[ADDR_W-1:0]] <= wdata;
		end
	end

endmodule

// ===== rtl/cmrm_front.sv =====
// Front stage: accepts symbols and turns each into an index and a length.
// Depends on cmrm_pkg.
module cmrm_front import cmrm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      q_push,
	input  logic      q_full,
	output cls_item_t q_item
);
	logic [LIMIT_W-1:0] limit;
	logic [COUNT_W-1:0] pow;
	logic [COUNT_W-1:0] mask;
	cls_item_t          cls;
	logic               load;
	logic               valid_s1;
	cls_item_t          item_s1;

	always_comb begin
		limit = (cfg.run_prefix_limit > MAX_RUN_PREFIX) ? MAX_RUN_PREFIX :
			cfg.run_prefix_limit;
		pow   = COUNT_W'(1) << item.symbol[LIMIT_W-1:0];
		mask  = pow - COUNT_W'(1);
		cls.first = item.first_symbol;
		if (item.symbol == '0) begin
			cls.index  = '0;
			cls.length = COUNT_W'(1);
		end else if (item.symbol <= SYMBOL_W'(limit)) begin
			cls.index  = '0;
			cls.length = pow + (COUNT_W'(item.extra_bits) & mask);
		end else begin
			cls.index  = item.symbol[VALUE_W-1:0] - VALUE_W'(limit);
			cls.length = COUNT_W'(1);
		end
	end

	assign full   = valid_s1 && q_full;
	assign load   = push && !full;
	assign q_push = valid_s1;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= cls;
		end
	end

endmodule

// ===== rtl/cmrm_back.sv =====
// Back stage: map position, error state and the move-to-front cell row.
// Depends on cmrm_pkg.
module cmrm_back import cmrm_pkg::*; #(
	parameter int MAX_MAP_ENTRIES = 16384
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      cls_valid,
	input  cls_item_t cls_item,
	output logic      cls_take,
	output logic      res_push,
	input  logic      res_full,
	output out_item_t res_item
);
	localparam int SIZE_LIMIT = (1 << MAP_SIZE_W) - 1;
	localparam int SIZE_CAP   = (MAX_MAP_ENTRIES < SIZE_LIMIT) ? MAX_MAP_ENTRIES : SIZE_LIMIT;
	localparam int POS_W      = $clog2(SIZE_CAP + 1);

	logic [VALUE_W-1:0] list_q [MTF_ENTRIES];
	logic [VALUE_W-1:0] cur    [MTF_ENTRIES];
	logic [VALUE_W-1:0] nxt    [MTF_ENTRIES];
	logic [POS_W-1:0]   position_q;
	logic               failed_q;
	logic [POS_W-1:0]   size;
	logic [POS_W-1:0]   pos_eff;
	logic               failed_eff;
	logic               active;
	logic [POS_W-1:0]   remaining;
	logic               over;
	logic [COUNT_W-1:0] cnt;
	logic [POS_W-1:0]   pos_new;
	logic               failed_new;
	logic [VALUE_W-1:0] looked;
	logic               shift;

	assign cls_take = cls_valid && !res_full;
	assign res_push = cls_take;

	always_comb begin
		size = (32'(cfg.map_size) > SIZE_CAP) ? POS_W'(SIZE_CAP) :
			cfg.map_size[POS_W-1:0];
		pos_eff    = cls_item.first ? '0 : position_q;
		failed_eff = cls_item.first ? 1'b0 : failed_q;
		active     = !failed_eff && (pos_eff < size);
		remaining  = size - pos_eff;
		over       = cls_item.length > COUNT_W'(remaining);
		cnt        = !active ? '0 : (over ? COUNT_W'(remaining) : cls_item.length);
		pos_new    = pos_eff + cnt[POS_W-1:0];
		failed_new = failed_eff || (active && over);
		for (int k = 0; k < MTF_ENTRIES; k++) begin
			cur[k] = cls_item.first ? VALUE_W'(k) : list_q[k];
		end
		looked = cur[cls_item.index];
		shift  = active && cfg.mtf_enable;
		nxt[0] = shift ? looked : cur[0];
		for (int k = 1; k < MTF_ENTRIES; k++) begin
			nxt[k] = (shift && (VALUE_W'(k) <= cls_item.index)) ? cur[k-1] : cur[k];
		end
		res_item.value          = !active ? '0 : (cfg.mtf_enable ? looked : cls_item.index);
		res_item.count          = cnt;
		res_item.overflow_error = failed_new;
		res_item.map_complete   = (pos_new >= size);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			failed_q   <= 1'b0;
			for (int k = 0; k < MTF_ENTRIES; k++) begin
				list_q[k] <= VALUE_W'(k);
			end
		end else if (cls_take) begin
			position_q <= pos_new;
			failed_q   <= failed_new;
			for (int k = 0; k < MTF_ENTRIES; k++) begin
				list_q[k] <= nxt[k];
			end
		end
	end

endmodule

// ===== rtl/context_map_rle_mtf_decoder.sv =====
// Context map decoder: zero run expansion with inverse move-to-front.
// Depends on cmrm_pkg, cmrm_front, cmrm_fifo, cmrm_back and the assertion header.
//
// The block takes one decoded context-map symbol per cycle while not full and returns
// one result per symbol: a value and the number of map entries that receive it. A
// result reaches the result ports after passing through a front register, a
// two-entry queue, the back stage and a two-entry output queue; the sustained
// rate of one item per clock, while the output queue has room, is set by the back
// stage, whose row of 256 move-to-front cells looks up and shifts combinationally.
// Configuration writes are always ready and must be made only while the block holds no pending items.
`include "context_map_rle_mtf_decoder_assert.svh"
module context_map_rle_mtf_decoder import cmrm_pkg::*; #(
	parameter int MAX_MAP_ENTRIES = 16384
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [MAP_SIZE_W-1:0]  cfg_data,
	input  logic                   push,
	output logic                   full,
	input  in_item_t               item,
	output logic                   empty,
	input  logic                   pop,
	output out_item_t              result
);
	cfg_t      cfg_q;
	logic      fq_push;
	logic      fq_full;
	cls_item_t fq_wdata;
	logic      mq_empty;
	cls_item_t mq_rdata;
	logic      bk_take;
	logic      bk_push;
	logic      oq_full;
	out_item_t bk_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_size         <= MAP_SIZE_W'(16384);
			cfg_q.run_prefix_limit <= '0;
			cfg_q.mtf_enable       <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAP_SIZE: begin
					cfg_q.map_size <= cfg_data;
				end
				CFG_RUN_PREFIX_LIMIT: begin
					cfg_q.run_prefix_limit <= cfg_data[LIMIT_W-1:0];
				end
				CFG_MTF_ENABLE: begin
					cfg_q.mtf_enable <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	cmrm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_push (fq_push),
		.q_full (fq_full),
		.q_item (fq_wdata)
	);

	cmrm_fifo #(
		.WIDTH ($bits(cls_item_t)),
		.DEPTH (2)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.full   (fq_full),
		.wdata  (fq_wdata),
		.pop    (bk_take),
		.empty  (mq_empty),
		.rdata  (mq_rdata)
	);

	cmrm_back #(
		.MAX_MAP_ENTRIES (MAX_MAP_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cls_valid (!mq_empty),
		.cls_item  (mq_rdata),
		.cls_take  (bk_take),
		.res_push  (bk_push),
		.res_full  (oq_full),
		.res_item  (bk_res)
	);

	cmrm_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (2)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (bk_push),
		.full   (oq_full),
		.wdata  (bk_res),
		.pop    (pop),
		.empty  (empty),
		.rdata  (result)
	);

	`CMRM_ASSERT_NEXT(a_accept_held, clk, arst_n, push && !full, fq_push, "item not held")
	`CMRM_ASSERT_SAME(a_no_push_full, clk, arst_n, bk_push, !oq_full, "push into full queue")
	`CMRM_ASSERT_SAME(a_empty_zero, clk, arst_n, bk_push && (bk_res.count == '0), bk_res.value == '0, "value not zero")

endmodule
